[rtl/core/ceta_pkg.sv]
`default_nettype none

package ceta_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_FS_W   = 13;
    localparam int CFG_W_W    = 14;
    localparam int CFG_H_W    = 13;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FACE_SIZE   = 2'd0;
    localparam t_cfg_idx CFG_EQUI_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_EQUI_HEIGHT = 2'd2;

    localparam logic [CFG_FS_W-1:0] RST_FACE_SIZE   = 13'd512;
    localparam logic [CFG_W_W-1:0]  RST_EQUI_WIDTH  = 14'd2048;
    localparam logic [CFG_H_W-1:0]  RST_EQUI_HEIGHT = 13'd1024;

    // payload
    localparam int FACE_W = 3;
    localparam int IDX_W  = 25;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // texel to Q1.15 divider: DIV_STAGES registered stages of DIV_BITS bits
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = 4;
    localparam int Q_W        = DIV_STAGES * DIV_BITS;
    localparam int DIR_W      = 17;

    localparam logic signed [DIR_W-1:0] DIR_ONE   = 17'sd32768;
    localparam logic signed [DIR_W-1:0] Q15_MAX   = 17'sd32767;

    // CORDIC datapath
    localparam int CORDIC_W    = 28;
    localparam int ACC_W       = 32;
    localparam int GUARD_SHIFT = 8;
    localparam int TABLE_LEN   = 24;

    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic [ACC_W-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [ACC_W-1:0] TURN_NEG_Q   = 32'hC000_0000;

    localparam logic [ACC_W-1:0] TURN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

`default_nettype wire

[rtl/core/ceta_cordic.sv]
`default_nettype none

// Pipelined vectoring CORDIC, one micro-rotation per register stage.
module ceta_cordic #(
    parameter int STAGES = 16,
    parameter int SB_W   = 1
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_valid,
    input  wire logic signed [ceta_pkg::CORDIC_W-1:0]    i_x,
    input  wire logic signed [ceta_pkg::CORDIC_W-1:0]    i_y,
    input  wire logic        [ceta_pkg::ACC_W-1:0]       i_acc,
    input  wire logic        [SB_W-1:0]                  i_sb,
    output logic                                         o_valid,
    output logic signed      [ceta_pkg::CORDIC_W-1:0]    o_x,
    output logic             [ceta_pkg::ACC_W-1:0]       o_acc,
    output logic             [SB_W-1:0]                  o_sb
);

    localparam int CW = ceta_pkg::CORDIC_W;
    localparam int AW = ceta_pkg::ACC_W;

    logic                 r_v   [STAGES];
    logic signed [CW-1:0] r_x   [STAGES];
    logic signed [CW-1:0] r_y   [STAGES-1];
    logic        [AW-1:0] r_acc [STAGES];
    logic        [SB_W-1:0] r_sb [STAGES];

    // stage inputs: element k feeds stage k
    logic                 s_v   [STAGES];
    logic signed [CW-1:0] s_x   [STAGES];
    logic signed [CW-1:0] s_y   [STAGES];
    logic        [AW-1:0] s_acc [STAGES];
    logic        [SB_W-1:0] s_sb [STAGES];

    assign s_v[0]   = i_valid;
    assign s_x[0]   = i_x;
    assign s_y[0]   = i_y;
    assign s_acc[0] = i_acc;
    assign s_sb[0]  = i_sb;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic        [AW-1:0] n_acc;

        // rotate toward the x axis by the k-th table angle
        always_comb begin
            if (!s_y[k][CW-1]) begin
                n_x   = s_x[k] + (s_y[k] >>> k);
                n_y   = s_y[k] - (s_x[k] >>> k);
                n_acc = s_acc[k] + ceta_pkg::TURN_TABLE[k];
            end else begin
                n_x   = s_x[k] - (s_y[k] >>> k);
                n_y   = s_y[k] + (s_x[k] >>> k);
                n_acc = s_acc[k] - ceta_pkg::TURN_TABLE[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_acc[k] <= n_acc;
                r_sb[k]  <= s_sb[k];
            end
        end

        if (k < STAGES - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[k] <= n_y;
                end
            end
            assign s_v[k+1]   = r_v[k];
            assign s_x[k+1]   = r_x[k];
            assign s_y[k+1]   = r_y[k];
            assign s_acc[k+1] = r_acc[k];
            assign s_sb[k+1]  = r_sb[k];
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_acc   = r_acc[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

`default_nettype wire

[rtl/core/cubemap_texel_to_equirect_address.sv]
`default_nettype none

// Cube-face texel to equirectangular source address.
// Input channel (i_valid / o_ready) takes a face number and the texel column
// and row on that face; the output channel (o_valid / i_ready) returns the
// source column, row and linear index src_row * equi_width + src_col.
// The three size registers are written through the plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data); the user must write them only while
// no transaction is in flight, which the block itself does not enforce.
// Throughput: one transaction per cycle while o_ready is high. The data
// passes one input register, loaded at the accepting edge, four divider
// stages, one direction stage, two CORDIC pipes of CORDIC_STAGES stages each
// with a gain multiply between them, one scale stage and one index stage.
// A skid register follows the last stage. When the receiver stalls, the pipe
// advances once more into the skid register, then o_ready drops until the
// held result is taken; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the size registers with
// 512, 2048 and 1024.
module cubemap_texel_to_equirect_address #(
    parameter int COORD_BITS      = 12,
    parameter int SRC_WIDTH_BITS  = 13,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ceta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ceta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [ceta_pkg::FACE_W-1:0]         i_face,
    input  wire logic [COORD_BITS-1:0]               i_tex_col,
    input  wire logic [COORD_BITS-1:0]               i_tex_row,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [SRC_WIDTH_BITS-1:0]                o_src_col,
    output logic [SRC_WIDTH_BITS-2:0]                o_src_row,
    output logic [ceta_pkg::IDX_W-1:0]               o_src_index
);

    localparam int FS_W   = COORD_BITS + 1;
    localparam int W_W    = SRC_WIDTH_BITS + 1;
    localparam int H_W    = SRC_WIDTH_BITS;
    localparam int FS_CW  = (ceta_pkg::CFG_FS_W > FS_W) ? ceta_pkg::CFG_FS_W : FS_W;
    localparam int W_CW   = (ceta_pkg::CFG_W_W > W_W) ? ceta_pkg::CFG_W_W : W_W;
    localparam int H_CW   = (ceta_pkg::CFG_H_W > H_W) ? ceta_pkg::CFG_H_W : H_W;
    localparam int Q_W    = ceta_pkg::Q_W;
    localparam int DS     = ceta_pkg::DIV_STAGES;
    localparam int CW     = ceta_pkg::CORDIC_W;
    localparam int AW     = ceta_pkg::ACC_W;
    localparam int DW     = ceta_pkg::DIR_W;
    localparam int AF     = ANGLE_FRAC_BITS;
    localparam int ROW_W  = SRC_WIDTH_BITS - 1;
    localparam int IDX_W  = ceta_pkg::IDX_W;
    localparam int IDX_CW = (2 * SRC_WIDTH_BITS > IDX_W) ? 2 * SRC_WIDTH_BITS : IDX_W;
    localparam int SB1_W  = DW + 1;
    localparam int SB2_W  = AW + 3;

    // ------------------------------------------------------------------
    // size registers
    logic [ceta_pkg::CFG_FS_W-1:0] r_face_size;
    logic [ceta_pkg::CFG_W_W-1:0]  r_equi_width;
    logic [ceta_pkg::CFG_H_W-1:0]  r_equi_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size   <= ceta_pkg::RST_FACE_SIZE;
            r_equi_width  <= ceta_pkg::RST_EQUI_WIDTH;
            r_equi_height <= ceta_pkg::RST_EQUI_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ceta_pkg::CFG_FACE_SIZE: begin
                    r_face_size <= i_cfg_data[ceta_pkg::CFG_FS_W-1:0];
                end
                ceta_pkg::CFG_EQUI_WIDTH: begin
                    r_equi_width <= i_cfg_data[ceta_pkg::CFG_W_W-1:0];
                end
                ceta_pkg::CFG_EQUI_HEIGHT: begin
                    r_equi_height <= i_cfg_data[ceta_pkg::CFG_H_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize clamps to the largest supported size
    logic [FS_W-1:0] fs;
    logic [W_W-1:0]  w;
    logic [H_W-1:0]  h;

    always_comb begin
        logic [FS_CW-1:0] fs_e;
        logic [W_CW-1:0]  w_e;
        logic [H_CW-1:0]  h_e;
        fs_e = FS_CW'(r_face_size);
        w_e  = W_CW'(r_equi_width);
        h_e  = H_CW'(r_equi_height);
        if (fs_e == '0) fs_e = FS_CW'(1);
        else if (fs_e > (FS_CW'(1) << COORD_BITS)) fs_e = FS_CW'(1) << COORD_BITS;
        if (w_e == '0) w_e = W_CW'(1);
        else if (w_e > (W_CW'(1) << SRC_WIDTH_BITS)) w_e = W_CW'(1) << SRC_WIDTH_BITS;
        if (h_e == '0) h_e = H_CW'(1);
        else if (h_e > (H_CW'(1) << (SRC_WIDTH_BITS - 1))) begin
            h_e = H_CW'(1) << (SRC_WIDTH_BITS - 1);
        end
        fs = fs_e[FS_W-1:0];
        w  = w_e[W_W-1:0];
        h  = h_e[H_W-1:0];
    end

    // ------------------------------------------------------------------
    // pipe enable: the whole pipe moves while the skid register is empty
    logic r_skid_v;
    logic en;

    assign en      = !r_skid_v;
    assign o_ready = en;

    // ------------------------------------------------------------------
    // input register and restoring divider: q = floor(coord * 2^16 / fs)
    logic                       r_dv    [DS+1];
    logic [ceta_pkg::FACE_W-1:0] r_dface [DS+1];
    logic [FS_W-1:0]            r_ur    [DS+1];
    logic [FS_W-1:0]            r_vr    [DS+1];
    logic [Q_W-1:0]             r_uq    [DS+1];
    logic [Q_W-1:0]             r_vq    [DS+1];
    logic                       r_usat  [DS+1];
    logic                       r_vsat  [DS+1];

    function automatic logic [FS_W+Q_W-1:0] div_step(
        input logic [FS_W-1:0] rem_in,
        input logic [Q_W-1:0]  q_in,
        input logic [FS_W-1:0] d
    );
        logic [FS_W-1:0] rem;
        logic [Q_W-1:0]  q;
        logic [FS_W:0]   t;
        rem = rem_in;
        q   = q_in;
        for (int j = 0; j < ceta_pkg::DIV_BITS; j++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                q = {q[Q_W-2:0], 1'b1};
            end else begin
                q = {q[Q_W-2:0], 1'b0};
            end
            rem = t[FS_W-1:0];
        end
        return {rem, q};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dface[0] <= i_face;
            r_ur[0]    <= FS_W'(i_tex_col);
            r_vr[0]    <= FS_W'(i_tex_row);
            r_uq[0]    <= '0;
            r_vq[0]    <= '0;
            r_usat[0]  <= FS_W'(i_tex_col) >= fs;
            r_vsat[0]  <= FS_W'(i_tex_row) >= fs;
        end
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [FS_W+Q_W-1:0] n_u;
        logic [FS_W+Q_W-1:0] n_v;

        assign n_u = div_step(r_ur[k], r_uq[k], fs);
        assign n_v = div_step(r_vr[k], r_vq[k], fs);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dface[k+1] <= r_dface[k];
                r_ur[k+1]    <= n_u[FS_W+Q_W-1:Q_W];
                r_uq[k+1]    <= n_u[Q_W-1:0];
                r_vr[k+1]    <= n_v[FS_W+Q_W-1:Q_W];
                r_vq[k+1]    <= n_v[Q_W-1:0];
                r_usat[k+1]  <= r_usat[k];
                r_vsat[k+1]  <= r_vsat[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // face direction, half-plane fold and guard scaling
    logic                 r_pv;
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_pz;
    logic        [AW-1:0] r_pacc;
    logic signed [DW-1:0] r_py;
    logic                 r_ppole;

    logic signed [CW-1:0] n_px;
    logic signed [CW-1:0] n_pz;
    logic        [AW-1:0] n_pacc;
    logic signed [DW-1:0] n_py;
    logic                 n_ppole;

    always_comb begin
        logic [Q_W-1:0]       uq;
        logic [Q_W-1:0]       vq;
        logic signed [DW-1:0] u;
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] z;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] zs;
        uq = r_uq[DS];
        vq = r_vq[DS];
        // Q1.15: q - 32768, saturated when the texel lies beyond the face
        u = r_usat[DS] ? ceta_pkg::Q15_MAX : $signed({{2{~uq[Q_W-1]}}, uq[Q_W-2:0]});
        v = r_vsat[DS] ? ceta_pkg::Q15_MAX : $signed({{2{~vq[Q_W-1]}}, vq[Q_W-2:0]});
        unique case (ceta_pkg::t_face'(r_dface[DS]))
            ceta_pkg::FACE_POS_X: begin
                x = ceta_pkg::DIR_ONE;  n_py = -v;                z = -u;
            end
            ceta_pkg::FACE_NEG_X: begin
                x = -ceta_pkg::DIR_ONE; n_py = -v;                z = u;
            end
            ceta_pkg::FACE_POS_Y: begin
                x = u;                  n_py = ceta_pkg::DIR_ONE;  z = v;
            end
            ceta_pkg::FACE_NEG_Y: begin
                x = u;                  n_py = -ceta_pkg::DIR_ONE; z = -v;
            end
            ceta_pkg::FACE_POS_Z: begin
                x = u;                  n_py = -v;                z = ceta_pkg::DIR_ONE;
            end
            ceta_pkg::FACE_NEG_Z: begin
                x = -u;                 n_py = -v;                z = -ceta_pkg::DIR_ONE;
            end
            default: begin
                x = '0;                 n_py = '0;                z = '0;
            end
        endcase
        n_ppole = (x == '0) && (z == '0);
        xs = CW'(x) <<< ceta_pkg::GUARD_SHIFT;
        zs = CW'(z) <<< ceta_pkg::GUARD_SHIFT;
        // left half-plane: rotate by a half turn first
        if (x < 0) begin
            n_px   = -xs;
            n_pz   = -zs;
            n_pacc = ceta_pkg::TURN_HALF;
        end else begin
            n_px   = xs;
            n_pz   = zs;
            n_pacc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px    <= n_px;
            r_pz    <= n_pz;
            r_pacc  <= n_pacc;
            r_py    <= n_py;
            r_ppole <= n_ppole;
        end
    end

    // ------------------------------------------------------------------
    // longitude CORDIC
    logic                 c1_v;
    logic signed [CW-1:0] c1_x;
    logic        [AW-1:0] c1_acc;
    logic     [SB1_W-1:0] c1_sb;

    ceta_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (SB1_W)
    ) u_lon_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_x     (r_px),
        .i_y     (r_pz),
        .i_acc   (r_pacc),
        .i_sb    ({r_py, r_ppole}),
        .o_valid (c1_v),
        .o_x     (c1_x),
        .o_acc   (c1_acc),
        .o_sb    (c1_sb)
    );

    // ------------------------------------------------------------------
    // gain correction of the horizontal magnitude
    logic                 r_mv;
    logic signed [CW-1:0] r_mr;
    logic        [AW-1:0] r_mlon;
    logic signed [DW-1:0] r_my;
    logic                 r_mpole;
    logic     [CW+15:0]   m_prod;

    always_comb begin
        logic [CW-1:0] mag;
        mag    = c1_x[CW-1] ? '0 : c1_x;
        m_prod = (CW+16)'(mag) * (CW+16)'(ceta_pkg::INV_GAIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mr    <= $signed(m_prod[CW+15:16]);
            r_mlon  <= c1_acc;
            r_my    <= $signed(c1_sb[SB1_W-1:1]);
            r_mpole <= c1_sb[0];
        end
    end

    // ------------------------------------------------------------------
    // latitude CORDIC
    logic                 c2_v;
    logic signed [CW-1:0] c2_x;
    logic        [AW-1:0] c2_acc;
    logic     [SB2_W-1:0] c2_sb;
    logic signed [CW-1:0] c2_yin;

    assign c2_yin = CW'(r_my) <<< ceta_pkg::GUARD_SHIFT;

    ceta_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (SB2_W)
    ) u_lat_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mv),
        .i_x     (r_mr),
        .i_y     (c2_yin),
        .i_acc   ('0),
        .i_sb    ({r_mlon, r_mpole, (r_my > 0), (r_my < 0)}),
        .o_valid (c2_v),
        .o_x     (c2_x),
        .o_acc   (c2_acc),
        .o_sb    (c2_sb)
    );

    // ------------------------------------------------------------------
    // angle fractions scaled to the source image
    logic                      r_fv;
    logic [SRC_WIDTH_BITS-1:0] r_fcol;
    logic [ROW_W-1:0]          r_frow;
    logic [AF+W_W-1:0]         f_colp;
    logic [AF+H_W-1:0]         f_rowp;

    always_comb begin
        logic [AW-1:0] lon;
        logic [AW-1:0] lat;
        logic [AW-1:0] lon_s;
        logic [AW-1:0] lat_s;
        logic          pole;
        pole = c2_sb[2];
        if (pole) begin
            // straight up or down: exact quarter turns; a zero vector gives zero
            lon = '0;
            if (c2_sb[1]) lat = ceta_pkg::TURN_QUARTER;
            else if (c2_sb[0]) lat = ceta_pkg::TURN_NEG_Q;
            else lat = '0;
        end else begin
            lon = c2_sb[SB2_W-1:3];
            lat = c2_acc;
        end
        lon_s  = lon + ceta_pkg::TURN_HALF;
        lat_s  = {lat[AW-2:0], 1'b0} + ceta_pkg::TURN_HALF;
        f_colp = (AF+W_W)'(lon_s[AW-1 -: AF]) * (AF+W_W)'(w);
        f_rowp = (AF+H_W)'(lat_s[AW-1 -: AF]) * (AF+H_W)'(h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fcol <= f_colp[AF +: SRC_WIDTH_BITS];
            r_frow <= f_rowp[AF +: ROW_W];
        end
    end

    // ------------------------------------------------------------------
    // linear index, last pipe stage
    logic                      r_ov;
    logic [SRC_WIDTH_BITS-1:0] r_ocol;
    logic [ROW_W-1:0]          r_orow;
    logic [IDX_W-1:0]          r_oidx;
    logic [IDX_CW-1:0]         o_idx_full;

    assign o_idx_full = IDX_CW'(r_frow) * IDX_CW'(w) + IDX_CW'(r_fcol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ocol <= r_fcol;
            r_orow <= r_frow;
            r_oidx <= o_idx_full[IDX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // skid register: catches the last stage when the receiver stalls
    logic [SRC_WIDTH_BITS-1:0] r_kcol;
    logic [ROW_W-1:0]          r_krow;
    logic [IDX_W-1:0]          r_kidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) r_skid_v <= 1'b0;
        end else if (r_ov && !i_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_kcol <= r_ocol;
            r_krow <= r_orow;
            r_kidx <= r_oidx;
        end
    end

    assign o_valid     = r_skid_v || r_ov;
    assign o_src_col   = r_skid_v ? r_kcol : r_ocol;
    assign o_src_row   = r_skid_v ? r_krow : r_orow;
    assign o_src_index = r_skid_v ? r_kidx : r_oidx;

endmodule

`default_nettype wire

[rtl/core/ceta_checker.sv]
`default_nettype none

// Port-level checks on the output side and the intake handshake.
module ceta_checker #(
    parameter int SRC_WIDTH_BITS = 13
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_ready,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic [SRC_WIDTH_BITS-1:0]     o_src_col,
    input wire logic [SRC_WIDTH_BITS-2:0]     o_src_row,
    input wire logic [ceta_pkg::IDX_W-1:0]    o_src_index
);

    // reset empties the pipe and the skid register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_src_col) && $stable(o_src_row)
            && $stable(o_src_index))
        else $error("stalled result changed");

    // intake closes only while a held result waits
    a_closed_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("intake closed with no result pending");

    // intake stays closed while the receiver keeps stalling
    a_stall_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && !i_ready |=> !o_ready)
        else $error("intake reopened during a stall");

endmodule

bind cubemap_texel_to_equirect_address ceta_checker #(
    .SRC_WIDTH_BITS (SRC_WIDTH_BITS)
) u_ceta_checker (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_BITS    = 12;
    localparam int SRC_W_BITS    = 13;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int PIPE_LATENCY  = 2 * CORDIC_STAGES + 9;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int NUM_PHASES    = 10;
    localparam int DW            = ceta_pkg::CFG_DATA_W;

    // size settings per random phase
    localparam logic [DW-1:0] FS_SET [NUM_PHASES] =
        '{14'd1, 14'd4096, 14'd0, 14'd8191, 14'd7, 14'd512, 14'd100, 14'd4096, 14'd33, 14'd2};
    localparam logic [DW-1:0] W_SET [NUM_PHASES] =
        '{14'd8192, 14'd1, 14'd16383, 14'd0, 14'd640, 14'd3000, 14'd8191, 14'd2048, 14'd5,
          14'd999};
    localparam logic [DW-1:0] H_SET [NUM_PHASES] =
        '{14'd4096, 14'd0, 14'd1, 14'd8191, 14'd320, 14'd1500, 14'd4095, 14'd1024, 14'd3,
          14'd777};

    typedef struct packed {
        logic [SRC_W_BITS-1:0]          col;
        logic [SRC_W_BITS-2:0]          row;
        logic [ceta_pkg::IDX_W-1:0]     index;
    } t_src_addr;

    typedef struct {
        logic [ceta_pkg::FACE_W-1:0] face;
        logic [COORD_BITS-1:0]       col;
        logic [COORD_BITS-1:0]       row;
        bit                          typed;
        t_src_addr                   addr;
    } t_texel_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [ceta_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [DW-1:0]                       i_cfg_data;
    logic                                i_valid;
    logic                                o_ready;
    logic [ceta_pkg::FACE_W-1:0]         i_face;
    logic [COORD_BITS-1:0]               i_tex_col;
    logic [COORD_BITS-1:0]               i_tex_row;
    logic                                o_valid;
    logic                                i_ready;
    logic [SRC_W_BITS-1:0]               o_src_col;
    logic [SRC_W_BITS-2:0]               o_src_row;
    logic [ceta_pkg::IDX_W-1:0]          o_src_index;

    // shadow copy of the size registers
    logic [ceta_pkg::CFG_FS_W-1:0] face_size_reg;
    logic [ceta_pkg::CFG_W_W-1:0]  equi_width_reg;
    logic [ceta_pkg::CFG_H_W-1:0]  equi_height_reg;

    t_src_addr pending_addrs[$];
    int        mismatches   = 0;
    int        checked      = 0;
    int        sent         = 0;
    int        send_idle    = 0;
    int        recv_idle    = 0;
    int        recv_hold    = 0;

    cubemap_texel_to_equirect_address dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_face(i_face), .i_tex_col(i_tex_col), .i_tex_row(i_tex_row),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_src_col(o_src_col), .o_src_row(o_src_row), .o_src_index(o_src_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 600000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint eff_size(longint v, longint max_v);
        if (v == 0) return 1;
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic longint texel_to_q15(longint coord, longint size);
        longint q;
        q = ((coord << 16) / size) - 32768;
        return (q > 32767) ? 32767 : q;
    endfunction

    // vectoring CORDIC: drives ys to zero, accumulates the turn angle
    function automatic longint cordic_rotate(longint xs, longint ys,
                                             inout logic [31:0] acc);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
                xs += dx; ys -= dy; acc += ceta_pkg::TURN_TABLE[i];
            end else begin
                xs -= dx; ys += dy; acc -= ceta_pkg::TURN_TABLE[i];
            end
        end
        return xs;
    endfunction

    function automatic t_src_addr predict_src_addr(logic [ceta_pkg::FACE_W-1:0] face,
                                                   logic [COORD_BITS-1:0] tcol,
                                                   logic [COORD_BITS-1:0] trow);
        longint fs, w, h, u, v, x, y, z, xs, zs, mag, r, lon_f, lat_f, c, rw;
        logic [31:0] lon, lat, t;
        t_src_addr a;
        fs = eff_size(longint'(face_size_reg), 64'd1 << COORD_BITS);
        w  = eff_size(longint'(equi_width_reg), 64'd1 << SRC_W_BITS);
        h  = eff_size(longint'(equi_height_reg), 64'd1 << (SRC_W_BITS - 1));
        u  = texel_to_q15(longint'(tcol), fs);
        v  = texel_to_q15(longint'(trow), fs);
        x = 0; y = 0; z = 0; lon = '0; lat = '0;
        case (face)
            ceta_pkg::FACE_POS_X: begin x = 32768;  y = -v;     z = -u;     end
            ceta_pkg::FACE_NEG_X: begin x = -32768; y = -v;     z = u;      end
            ceta_pkg::FACE_POS_Y: begin x = u;      y = 32768;  z = v;      end
            ceta_pkg::FACE_NEG_Y: begin x = u;      y = -32768; z = -v;     end
            ceta_pkg::FACE_POS_Z: begin x = u;      y = -v;     z = 32768;  end
            ceta_pkg::FACE_NEG_Z: begin x = -u;     y = -v;     z = -32768; end
            default: ;
        endcase
        if (x == 0 && z == 0) begin
            lat = (y > 0) ? ceta_pkg::TURN_QUARTER :
                  ((y < 0) ? ceta_pkg::TURN_NEG_Q : '0);
        end else begin
            xs = x * 256;
            zs = z * 256;
            if (xs < 0) begin
                xs = -xs; zs = -zs; lon = ceta_pkg::TURN_HALF;
            end
            mag = cordic_rotate(xs, zs, lon);
            if (mag < 0) mag = 0;
            r = (mag * longint'(ceta_pkg::INV_GAIN)) >> 16;
            void'(cordic_rotate(r, y * 256, lat));
        end
        t = lon + ceta_pkg::TURN_HALF;
        lon_f = longint'(t[31 -: ANGLE_BITS]);
        t = lat * 2 + ceta_pkg::TURN_HALF;
        lat_f = longint'(t[31 -: ANGLE_BITS]);
        c  = ((lon_f * w) >> ANGLE_BITS) % w;
        rw = ((lat_f * h) >> ANGLE_BITS) % h;
        a.col   = c[SRC_W_BITS-1:0];
        a.row   = rw[SRC_W_BITS-2:0];
        a.index = ceta_pkg::IDX_W'(rw * w + c);
        return a;
    endfunction

    // input side: one transaction per call, optional idle gap before it
    task automatic send_texel(logic [ceta_pkg::FACE_W-1:0] face,
                              logic [COORD_BITS-1:0] tcol,
                              logic [COORD_BITS-1:0] trow, bit typed, t_src_addr addr);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid   <= 1'b1;
        i_face    <= face;
        i_tex_col <= tcol;
        i_tex_row <= trow;
        do @(posedge i_clk); while (!o_ready);
        pending_addrs.push_back(typed ? addr : predict_src_addr(face, tcol, trow));
        sent++;
    endtask

    // register write while the pipe is empty; caller drops the enable
    task automatic write_size(ceta_pkg::t_cfg_idx idx, logic [DW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            ceta_pkg::CFG_FACE_SIZE:   face_size_reg   = value[ceta_pkg::CFG_FS_W-1:0];
            ceta_pkg::CFG_EQUI_WIDTH:  equi_width_reg  = value[ceta_pkg::CFG_W_W-1:0];
            ceta_pkg::CFG_EQUI_HEIGHT: equi_height_reg = value[ceta_pkg::CFG_H_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        wait (pending_addrs.size() == 0);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // output side: check each transaction, drive ready for the next edge
    initial begin
        t_src_addr exp_a;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                checked++;
                if (pending_addrs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result col=%0d row=%0d index=%0d",
                                 o_src_col, o_src_row, o_src_index);
                end else begin
                    exp_a = pending_addrs.pop_front();
                    if (o_src_col !== exp_a.col || o_src_row !== exp_a.row ||
                        o_src_index !== exp_a.index) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp col=%0d row=%0d index=%0d, got %0d %0d %0d",
                                     exp_a.col, exp_a.row, exp_a.index,
                                     o_src_col, o_src_row, o_src_index);
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // stimulus
    initial begin
        t_texel_row directed[$];
        t_texel_row tr;
        int fs_eff;
        int per_phase;
        logic [COORD_BITS-1:0] c, r;
        logic [ceta_pkg::FACE_W-1:0] f;

        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_face = '0; i_tex_col = '0; i_tex_row = '0;
        face_size_reg = ceta_pkg::RST_FACE_SIZE;
        equi_width_reg = ceta_pkg::RST_EQUI_WIDTH;
        equi_height_reg = ceta_pkg::RST_EQUI_HEIGHT;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset sizes 512 / 2048 / 1024
        directed = '{
            '{3'd6, 12'd0, 12'd0, 1'b1, '{13'd1024, 12'd512, 25'd1049600}},
            '{3'd7, 12'hFFF, 12'hFFF, 1'b1, '{13'd1024, 12'd512, 25'd1049600}},
            '{ceta_pkg::FACE_POS_Y, 12'd256, 12'd256, 1'b1, '{13'd1024, 12'd0, 25'd1024}},
            '{ceta_pkg::FACE_NEG_Y, 12'd256, 12'd256, 1'b1, '{13'd1024, 12'd0, 25'd1024}},
            '{ceta_pkg::FACE_POS_X, 12'd0, 12'd0, 1'b0, '0},
            '{ceta_pkg::FACE_POS_X, 12'd511, 12'd511, 1'b0, '0},
            '{ceta_pkg::FACE_POS_X, 12'hFFF, 12'hFFF, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_X, 12'd256, 12'd256, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_X, 12'd0, 12'd511, 1'b0, '0},
            '{ceta_pkg::FACE_POS_Y, 12'd0, 12'd0, 1'b0, '0},
            '{ceta_pkg::FACE_POS_Y, 12'd511, 12'd0, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_Y, 12'd0, 12'd511, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_Y, 12'd511, 12'd511, 1'b0, '0},
            '{ceta_pkg::FACE_POS_Z, 12'd256, 12'd256, 1'b0, '0},
            '{ceta_pkg::FACE_POS_Z, 12'd0, 12'd0, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_Z, 12'd256, 12'd256, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_Z, 12'd511, 12'd0, 1'b0, '0},
            '{ceta_pkg::FACE_POS_Z, 12'd4000, 12'd600, 1'b0, '0},
            '{ceta_pkg::FACE_NEG_Z, 12'd255, 12'd257, 1'b0, '0},
            '{3'd6, 12'd1, 12'd2, 1'b1, '{13'd1024, 12'd512, 25'd1049600}}
        };
        foreach (directed[i]) begin
            tr = directed[i];
            send_texel(tr.face, tr.col, tr.row, tr.typed, tr.addr);
        end

        // random phases, each with its own size setting
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipe();
            write_size(ceta_pkg::CFG_FACE_SIZE, FS_SET[p]);
            write_size(ceta_pkg::CFG_EQUI_WIDTH, W_SET[p]);
            write_size(ceta_pkg::CFG_EQUI_HEIGHT, H_SET[p]);
            i_cfg_we <= 1'b0;
            if (p < 3) begin
                send_idle = 32; recv_idle = 49;
            end else if (p < 6) begin
                send_idle = 49; recv_idle = 32;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            // long receiver stall: pipe fills and input backs up
            if (p == 1 || p == 7) recv_hold = 300;
            fs_eff = int'(eff_size(longint'(face_size_reg), 4096));
            for (int n = 0; n < per_phase; n++) begin
                f = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
                case ($urandom_range(19))
                    0: begin
                        c = COORD_BITS'($urandom);
                        r = COORD_BITS'($urandom);
                    end
                    1: begin c = COORD_BITS'(fs_eff - 1); r = '0; end
                    2: begin c = '0; r = COORD_BITS'(fs_eff - 1); end
                    3: begin c = COORD_BITS'(fs_eff / 2); r = COORD_BITS'(fs_eff / 2); end
                    default: begin
                        c = COORD_BITS'($urandom_range(fs_eff - 1));
                        r = COORD_BITS'($urandom_range(fs_eff - 1));
                    end
                endcase
                send_texel(f, c, r, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        wait (pending_addrs.size() == 0);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d texels over %0d size settings, %0d addresses checked.",
                 sent, NUM_PHASES + 1, checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
